// ===== rtl/lsd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsd_pkg
// shared types and constants of the radix sorter
// ----------------------------------------------------------------------------
package lsd_pkg;

    localparam int WORD_W = 32;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_LOADING = 2'd1,
        PH_READY   = 2'd2
    } phase_t;

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_READ = 1'b1;

endpackage

// ===== rtl/lsd_radix_sorter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsd_radix_sorter
// stable lsd radix sort of unsigned words held in two word memories
// ----------------------------------------------------------------------------
// A load marked last starts the sort, and busy stays high for it: each pass
// clears the histogram, counts the n words (read-modify-write of the histogram
// memory), forms prefix sums and scatters, over 32/d passes; an odd pass count
// would add a copy back. An empty answer is strobed by res_valid in the cycle
// after its read request is accepted, a sorted word after the word memory read
// and the S_RD state; busy is held high during S_RD. The receiver cannot stall,
// every result is strobed for one cycle only.
module lsd_radix_sorter
    import lsd_pkg::*;
#(
    parameter int MAX_ITEMS      = 1024,
    parameter int MAX_DIGIT_BITS = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_wdata,
    input  logic        start,
    output logic        busy,
    input  logic        req_type,
    input  logic [31:0] value,
    input  logic        last,
    output logic        res_valid,
    output logic [31:0] value_res,
    output logic        last_res,
    output logic        empty_res
);

    localparam int AW = $clog2(MAX_ITEMS);
    localparam int CW = $clog2(MAX_ITEMS + 1);
    localparam int HB = 1 << MAX_DIGIT_BITS;
    localparam int HW = (MAX_DIGIT_BITS < 1) ? 1 : MAX_DIGIT_BITS;
    localparam int HCW = $clog2(HB + 1);
    localparam int MAXLOG = (MAX_DIGIT_BITS >= 8) ? 3 :
                            (MAX_DIGIT_BITS >= 4) ? 2 :
                            (MAX_DIGIT_BITS >= 2) ? 1 : 0;

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_CLR   = 10'b0000000010,
        S_CNT_R = 10'b0000000100,
        S_CNT_W = 10'b0000001000,
        S_PRE_R = 10'b0000010000,
        S_PRE_W = 10'b0000100000,
        S_SC_R  = 10'b0001000000,
        S_SC_W  = 10'b0010000000,
        S_CPY   = 10'b0100000000,
        S_RD    = 10'b1000000000
    } state_t;

    state_t      state_reg;
    phase_t      phase_reg;
    logic [1:0]  dlog_reg;
    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] rptr_reg;
    logic [CW-1:0] idx_reg;
    logic [HCW-1:0] hidx_reg;
    logic [5:0]  pass_reg;
    logic [5:0]  shift_reg;
    logic        src_b_reg;
    logic [CW-1:0] acc_reg;
    logic        rd_pend_reg;
    logic        rd_last_reg;
    logic        cpy_v_reg;
    logic [AW-1:0] cpy_a_reg;

    // effective digit width, halved until it fits the histogram
    logic [1:0] elog;
    logic [4:0] width;
    logic [5:0] npass;
    always_comb
    begin
        elog  = (dlog_reg > 2'(MAXLOG)) ? 2'(MAXLOG) : dlog_reg;
        width = 5'd1 << elog;
        npass = 6'd32 >> elog;
    end
    logic [HCW-1:0] nbuck;
    assign nbuck = HCW'(1) << width;

    // memories
    logic a_we, b_we;
    logic [AW-1:0] a_wa, a_ra, b_wa, b_ra;
    logic [31:0] a_wd, b_wd, a_rd, b_rd;
    logic h_we;
    logic [HW-1:0] h_wa, h_ra;
    logic [CW-1:0] h_wd, h_rd;

    lsd_ram #(.WIDTH(32), .DEPTH(MAX_ITEMS)) u_a (.clk(clk), .we(a_we), .waddr(a_wa),
        .wdata(a_wd), .raddr(a_ra), .rdata(a_rd));
    lsd_ram #(.WIDTH(32), .DEPTH(MAX_ITEMS)) u_b (.clk(clk), .we(b_we), .waddr(b_wa),
        .wdata(b_wd), .raddr(b_ra), .rdata(b_rd));
    lsd_ram #(.WIDTH(CW), .DEPTH(HB)) u_h (.clk(clk), .we(h_we), .waddr(h_wa),
        .wdata(h_wd), .raddr(h_ra), .rdata(h_rd));

    // source word and digit of the word just read
    logic [31:0] sword;
    logic [HW-1:0] sdig;
    logic [31:0] dmask;
    assign sword = src_b_reg ? b_rd : a_rd;
    assign dmask = (32'd1 << width) - 32'd1;
    assign sdig  = HW'((sword >> shift_reg) & dmask);

    logic accept;
    assign accept = start && !busy;
    assign busy   = (state_reg != S_IDLE) || rd_pend_reg;

    logic [AW-1:0] idx_a;
    logic [AW-1:0] idxm1_a;
    assign idx_a   = idx_reg[AW-1:0];
    assign idxm1_a = AW'(idx_reg - CW'(1));

    // scatter second half: histogram read done, decrement and write
    logic [CW-1:0] pos;
    logic [31:0] sc_word_reg;
    logic [HW-1:0] sc_dig_reg;
    logic cn_wr_reg;
    logic [HW-1:0] cn_dig_reg;
    assign pos = h_rd - CW'(1);

    // memory port control
    always_comb
    begin
        a_we = 1'b0; a_wa = idx_a; a_wd = value; a_ra = idx_a;
        b_we = 1'b0; b_wa = idx_a; b_wd = sword; b_ra = idx_a;
        h_we = 1'b0; h_wa = sdig; h_wd = h_rd + CW'(1); h_ra = sdig;
        unique case (state_reg)
            S_IDLE:
            begin
                a_wa = AW'(phase_reg == PH_LOADING ? cnt_reg : CW'(0));
                a_we = accept && req_type == REQ_LOAD &&
                       (phase_reg != PH_LOADING || cnt_reg < CW'(MAX_ITEMS));
                a_ra = rptr_reg[AW-1:0];
            end
            S_CLR:
            begin
                h_we = 1'b1; h_wa = HW'(hidx_reg); h_wd = '0;
            end
            S_CNT_R:
            begin
                a_ra = idx_a; b_ra = idx_a;
                h_we = cn_wr_reg; h_wa = cn_dig_reg; h_wd = h_rd + CW'(1);
            end
            S_CNT_W:
            begin
                h_ra = sdig;
            end
            S_PRE_R:
            begin
                h_ra = HW'(hidx_reg);
            end
            S_PRE_W:
            begin
                h_we = 1'b1; h_wa = HW'(hidx_reg); h_wd = acc_reg + h_rd;
            end
            S_SC_R:
            begin
                a_ra = idxm1_a; b_ra = idxm1_a;
                h_we = cn_wr_reg; h_wa = sc_dig_reg; h_wd = pos;
                if (src_b_reg)
                begin
                    a_we = cn_wr_reg; a_wa = pos[AW-1:0]; a_wd = sc_word_reg;
                end
                else
                begin
                    b_we = cn_wr_reg; b_wa = pos[AW-1:0]; b_wd = sc_word_reg;
                end
            end
            S_SC_W:
            begin
                h_ra = sdig;
            end
            S_CPY:
            begin
                b_ra = idx_a;
                a_we = cpy_v_reg; a_wa = cpy_a_reg; a_wd = b_rd;
            end
            S_RD: ;
            default: ;
        endcase
    end

    // fsm and control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE; phase_reg <= PH_IDLE; dlog_reg <= 2'd3;
            cnt_reg <= '0; rptr_reg <= '0; idx_reg <= '0; hidx_reg <= '0;
            pass_reg <= '0; shift_reg <= '0; src_b_reg <= 1'b0; acc_reg <= '0;
            rd_pend_reg <= 1'b0; rd_last_reg <= 1'b0; cpy_v_reg <= 1'b0;
            cpy_a_reg <= '0; sc_word_reg <= '0; sc_dig_reg <= '0;
            cn_wr_reg <= 1'b0; cn_dig_reg <= '0;
            res_valid <= 1'b0; value_res <= '0; last_res <= 1'b0; empty_res <= 1'b0;
        end
        else
        begin
            res_valid <= 1'b0;
            if (cfg_we) dlog_reg <= cfg_wdata;
            cn_wr_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept && req_type == REQ_LOAD)
                    begin
                        logic [CW-1:0] c;
                        c = (phase_reg == PH_LOADING) ? cnt_reg : CW'(0);
                        if (c < CW'(MAX_ITEMS)) c = c + CW'(1);
                        cnt_reg <= c; rptr_reg <= '0; phase_reg <= PH_LOADING;
                        if (last)
                        begin
                            state_reg <= S_CLR; hidx_reg <= '0; pass_reg <= '0;
                            shift_reg <= '0; src_b_reg <= 1'b0;
                        end
                    end
                    else if (accept)
                    begin
                        if (phase_reg == PH_READY && rptr_reg < cnt_reg)
                        begin
                            rd_pend_reg <= 1'b1; state_reg <= S_RD;
                            rd_last_reg <= (rptr_reg + CW'(1) == cnt_reg);
                            rptr_reg <= rptr_reg + CW'(1);
                        end
                        else
                        begin
                            res_valid <= 1'b1; value_res <= '0;
                            last_res <= 1'b0; empty_res <= 1'b1;
                        end
                    end
                end
                S_RD:
                begin
                    state_reg <= S_IDLE; rd_pend_reg <= 1'b0;
                    res_valid <= 1'b1; value_res <= a_rd;
                    last_res <= rd_last_reg; empty_res <= 1'b0;
                end
                S_CLR:
                begin
                    if (hidx_reg == nbuck - HCW'(1))
                    begin
                        state_reg <= S_CNT_R; idx_reg <= '0;
                    end
                    hidx_reg <= hidx_reg + HCW'(1);
                end
                S_CNT_R:
                begin
                    if (idx_reg == cnt_reg)
                    begin
                        state_reg <= S_PRE_R; hidx_reg <= '0; acc_reg <= '0;
                    end
                    else
                    begin
                        state_reg <= S_CNT_W; idx_reg <= idx_reg + CW'(1);
                    end
                end
                S_CNT_W:
                begin
                    cn_wr_reg <= 1'b1; cn_dig_reg <= sdig;
                    state_reg <= S_CNT_R;
                end
                S_PRE_R: state_reg <= S_PRE_W;
                S_PRE_W:
                begin
                    acc_reg <= acc_reg + h_rd;
                    if (hidx_reg == nbuck - HCW'(1))
                    begin
                        state_reg <= S_SC_R; idx_reg <= cnt_reg;
                    end
                    else state_reg <= S_PRE_R;
                    hidx_reg <= hidx_reg + HCW'(1);
                end
                S_SC_R:
                begin
                    if (idx_reg == '0)
                    begin
                        src_b_reg <= !src_b_reg;
                        if (pass_reg + 6'd1 == npass)
                        begin
                            if (!src_b_reg)
                            begin
                                state_reg <= S_CPY; idx_reg <= '0; cpy_v_reg <= 1'b0;
                            end
                            else
                            begin
                                state_reg <= S_IDLE; phase_reg <= PH_READY;
                            end
                        end
                        else
                        begin
                            pass_reg <= pass_reg + 6'd1;
                            shift_reg <= shift_reg + 6'(width);
                            state_reg <= S_CLR; hidx_reg <= '0;
                        end
                    end
                    else
                    begin
                        state_reg <= S_SC_W; idx_reg <= idx_reg - CW'(1);
                    end
                end
                S_SC_W:
                begin
                    sc_word_reg <= sword; sc_dig_reg <= sdig;
                    cn_wr_reg <= 1'b1;
                    state_reg <= S_SC_R;
                end
                S_CPY:
                begin
                    cpy_v_reg <= idx_reg < cnt_reg; cpy_a_reg <= idx_a;
                    if (idx_reg == cnt_reg)
                    begin
                        state_reg <= S_IDLE; phase_reg <= PH_READY;
                    end
                    idx_reg <= idx_reg + CW'(1);
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== rtl/lsd_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsd_ram
// generic single-port-write, single-read ram with registered read
// ----------------------------------------------------------------------------
module lsd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== tb/lsd_sort_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsd_sort_checker
// watches the request and result channels of the radix sorter, keeps its own
// copy of the batch, predicts every read answer and compares it
// ----------------------------------------------------------------------------
module lsd_sort_checker
    import lsd_pkg::*;
#(
    parameter int MAX_ITEMS      = 1024,
    parameter int MAX_DIGIT_BITS = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_wdata,
    input  logic        start,
    input  logic        busy,
    input  logic        req_type,
    input  logic [31:0] value,
    input  logic        last,
    input  logic        res_valid,
    input  logic [31:0] value_res,
    input  logic        last_res,
    input  logic        empty_res,
    output int          errors,
    output int          pending
);

    typedef struct {
        logic [31:0] word;
        logic        is_last;
        logic        is_empty;
    } answer_t;

    answer_t     answer_q[$];
    logic [31:0] batch_words [MAX_ITEMS];
    int          batch_count;
    int          next_read;
    phase_t      batch_phase;
    logic [1:0]  digit_log_sh;

    assign pending = answer_q.size();

    // print one mismatch line and count it
    task automatic report(input string what, input logic [31:0] got,
                          input logic [31:0] want);
        $display("%0t mismatch %s: got %h expected %h", $realtime, what, got, want);
        errors++;
    endtask

    // every digit width divides the word, so all bits are covered and the
    // lsd passes leave the batch in stable ascending order
    task automatic sort_batch();
        int          i;
        int          j;
        logic [31:0] key;
        for (i = 1; i < batch_count; i++)
        begin
            key = batch_words[i];
            j = i - 1;
            while (j >= 0 && batch_words[j] > key)
            begin
                batch_words[j + 1] = batch_words[j];
                j--;
            end
            batch_words[j + 1] = key;
        end
    endtask

    // predict on accepted requests, compare strobed results
    always @(posedge clk or negedge rst_n)
    begin
        answer_t a;
        answer_t e;
        if (!rst_n)
        begin
            answer_q.delete();
            batch_count  = 0;
            next_read    = 0;
            batch_phase  = PH_IDLE;
            digit_log_sh = 2'd3;
            errors       = 0;
        end
        else
        begin
            if (res_valid)
            begin
                if (answer_q.size() == 0)
                begin
                    report("unexpected result", value_res, 32'h0);
                end
                else
                begin
                    e = answer_q.pop_front();
                    if (value_res !== e.word)
                        report("value_res", value_res, e.word);
                    if (last_res !== e.is_last)
                        report("last_res", {31'h0, last_res}, {31'h0, e.is_last});
                    if (empty_res !== e.is_empty)
                        report("empty_res", {31'h0, empty_res}, {31'h0, e.is_empty});
                end
            end
            if (cfg_we)
                digit_log_sh = cfg_wdata;
            if (start && !busy)
            begin
                if (req_type == REQ_LOAD)
                begin
                    if (batch_phase != PH_LOADING)
                    begin
                        batch_count = 0;
                        next_read   = 0;
                        batch_phase = PH_LOADING;
                    end
                    if (batch_count < MAX_ITEMS)
                    begin
                        batch_words[batch_count] = value;
                        batch_count++;
                    end
                    if (last)
                    begin
                        sort_batch();
                        next_read   = 0;
                        batch_phase = PH_READY;
                    end
                end
                else
                begin
                    if (batch_phase == PH_READY && next_read < batch_count)
                    begin
                        a.word     = batch_words[next_read];
                        a.is_last  = (next_read + 1 == batch_count);
                        a.is_empty = 1'b0;
                        next_read++;
                    end
                    else
                    begin
                        a.word     = 32'h0;
                        a.is_last  = 1'b0;
                        a.is_empty = 1'b1;
                    end
                    answer_q.push_back(a);
                end
            end
        end
    end

endmodule

// ===== tb/tb_lsd_radix_sorter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lsd_radix_sorter
// drives load and read requests with random gaps across all digit widths;
// a checker beside the sorter predicts and compares every read answer
// ----------------------------------------------------------------------------
module tb_lsd_radix_sorter;
    import lsd_pkg::*;

    localparam int MAX_ITEMS  = 1024;
    localparam int IDLE_LIMIT = 600000;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_wdata;
    logic        start;
    logic        busy;
    logic        req_type;
    logic [31:0] value;
    logic        last;
    logic        res_valid;
    logic [31:0] value_res;
    logic        last_res;
    logic        empty_res;
    int          errors;
    int          pending;
    int          idle_cycles;
    int          accepted;
    bit          no_gaps;

    lsd_radix_sorter #(.MAX_ITEMS(MAX_ITEMS), .MAX_DIGIT_BITS(8)) uut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .start(start), .busy(busy), .req_type(req_type), .value(value),
        .last(last), .res_valid(res_valid), .value_res(value_res),
        .last_res(last_res), .empty_res(empty_res)
    );

    lsd_sort_checker #(.MAX_ITEMS(MAX_ITEMS), .MAX_DIGIT_BITS(8)) u_checker (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .start(start), .busy(busy), .req_type(req_type), .value(value),
        .last(last), .res_valid(res_valid), .value_res(value_res),
        .last_res(last_res), .empty_res(empty_res), .errors(errors),
        .pending(pending)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // watchdog on cycles with nothing accepted
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || res_valid)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 50)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // one request, held until the sorter takes it
    task automatic send(input logic rt, input logic [31:0] v, input logic l);
        int g;
        start    <= 1'b1;
        req_type <= rt;
        value    <= v;
        last     <= l;
        do
            @(posedge clk);
        while (busy);
        accepted++;
        g = pick_gap();
        if (g > 0)
        begin
            start <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    // sender pauses until every answer is back and the sorter is idle
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0 || busy)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_digit_log(input logic [1:0] d);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= d;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [31:0] rand_word();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5)
            return $urandom();
        else if (r < 8)
            return $urandom_range(0, 15);
        else if (r == 8)
            return 32'hFFFF_FFFF - $urandom_range(0, 3);
        return {2'($urandom_range(0, 3)), 30'h0} | 32'($urandom_range(0, 3));
    endfunction

    // stimulus
    initial
    begin
        int n;
        int i;
        int reads;
        cfg_we      = 1'b0;
        cfg_wdata   = 2'd0;
        start       = 1'b0;
        req_type    = REQ_LOAD;
        value       = 32'h0;
        last        = 1'b0;
        accepted    = 0;
        no_gaps     = 1'b0;
        rst_n       = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // read before any sort answers empty
        send(REQ_READ, 32'hDEAD_BEEF, 1'b1);
        // extremes at reset width, then read past the end
        send(REQ_LOAD, 32'hFFFF_FFFF, 1'b0);
        send(REQ_LOAD, 32'h0000_0000, 1'b0);
        send(REQ_LOAD, 32'h8000_0001, 1'b1);
        for (i = 0; i < 4; i++)
            send(REQ_READ, 32'h0, 1'b0);
        // one-bit digits with duplicates
        write_digit_log(2'd0);
        send(REQ_LOAD, 32'h0000_0005, 1'b0);
        send(REQ_LOAD, 32'h0000_0005, 1'b0);
        send(REQ_LOAD, 32'h7FFF_FFFF, 1'b0);
        send(REQ_LOAD, 32'h0000_0001, 1'b1);
        send(REQ_READ, 32'h0, 1'b0);
        // load while sorted words are held discards them
        send(REQ_LOAD, 32'h1234_5678, 1'b1);
        send(REQ_READ, 32'h0, 1'b0);
        send(REQ_READ, 32'h0, 1'b0);
        // single-word batch at two-bit digits
        write_digit_log(2'd1);
        send(REQ_LOAD, 32'hA5A5_A5A5, 1'b1);
        send(REQ_READ, 32'h0, 1'b0);
        send(REQ_READ, 32'h0, 1'b0);

        // buffer full: extra loads dropped, the dropped last still sorts
        write_digit_log(2'd3);
        no_gaps = 1'b1;
        for (i = 0; i < MAX_ITEMS + 6; i++)
            send(REQ_LOAD, $urandom(), i == MAX_ITEMS + 5);
        for (i = 0; i < 40; i++)
            send(REQ_READ, 32'h0, 1'b0);
        no_gaps = 1'b0;
        drain();

        // random batches over all widths
        while (accepted < 2000)
        begin
            if ($urandom_range(0, 3) == 0)
                write_digit_log(2'($urandom_range(0, 3)));
            no_gaps = ($urandom_range(0, 5) == 0);
            n = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 200)
                                             : $urandom_range(1, 24);
            for (i = 0; i < n; i++)
            begin
                if ($urandom_range(0, 9) == 0)
                    send(REQ_READ, $urandom(), 1'($urandom_range(0, 1)));
                send(REQ_LOAD, rand_word(), i == n - 1);
            end
            reads = ($urandom_range(0, 7) == 0) ? $urandom_range(0, n)
                                                : n + $urandom_range(0, 2);
            for (i = 0; i < reads; i++)
                send(REQ_READ, $urandom(), 1'($urandom_range(0, 1)));
            if ($urandom_range(0, 9) == 0)
                drain();
        end

        drain();
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
